/* rtl/core/fsb_pkg.sv */
// Shared types and constants of the free stack block allocator.
package fsb_pkg;

    localparam int REC_BYTES = 12;   // bytes in one record
    localparam int RECORDS_W = 16;   // width of the block_records register
    localparam int BLOCKS_W  = 9;    // width of the blocks_in_use register
    localparam int BB_W      = 20;   // bytes per block: 12 * 65535 < 2**20
    localparam int ACT_W     = 2;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_REINIT = 2'd0,
        ACT_ALLOC  = 2'd1,
        ACT_FREE   = 2'd2,
        ACT_QUERY  = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_OUTSIDE = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE    = 2'd0,
        CFG_RECORDS = 2'd1,
        CFG_BLOCKS  = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ADDR,
        ST_SIZE,
        ST_RANGE,
        ST_DIV,
        ST_PUSH,
        ST_DONE
    } t_state;

endpackage

/* rtl/core/fsb_stack_mem.sv */
// Single-port synchronous memory that holds the stack of free block indices.
module fsb_stack_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // Registered read: data shows in the cycle after the request.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/fsb_div.sv */
// Restoring divider, one quotient bit per cycle, for a quotient known to fit in Q_W bits.
module fsb_div #(
    parameter int Q_W   = 8,
    parameter int DVS_W = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DVS_W+Q_W-1:0] i_dividend,
    input  logic [DVS_W-1:0]     i_divisor,
    output logic                 o_done,
    output logic [Q_W-1:0]       o_quotient
);

    localparam int R_W    = DVS_W + Q_W;
    localparam int STEP_W = $clog2(Q_W + 1);

    logic [R_W-1:0]    r_rem;
    logic [R_W-1:0]    r_dvs;
    logic [Q_W-1:0]    r_quot;
    logic [STEP_W-1:0] r_steps;
    logic              r_busy;
    logic              r_done;
    logic              take;

    assign take = (r_rem >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_steps == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_dividend;
            r_dvs   <= R_W'(i_divisor) << (Q_W - 1);
            r_quot  <= '0;
            r_steps <= STEP_W'(Q_W);
        end else if (r_busy) begin
            if (take) begin
                r_rem <= r_rem - r_dvs;
            end
            r_quot  <= (r_quot << 1) | Q_W'(take);
            r_dvs   <= r_dvs >> 1;
            r_steps <= r_steps - STEP_W'(1);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

/* rtl/core/free_stack_block_allocator.sv */
// Top level of the free stack block allocator: control sequencer, registers and result stage.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------------------
//  in       | input     | i_in_valid / o_in_stall | i_action, i_address
//  out      | output    | o_out_valid/ i_out_stall| o_block_address, o_status, o_inside_pool
//  cfg      | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
//  Steps: reinit, an empty alloc and a free to a full stack go straight to the result;
//  alloc fetches and forms the address; query and free size the pool and check the range;
//  a good free then pushes the block index that the bit-serial divider makes of the byte offset.
//  Reset is synchronous and leaves the stack as 0..B-1 with no clearing pass: a low
//  mark tracks the lowest fill seen since the last refill, and every entry below it
//  reads as its own position.
//  A stalled output holds its result; the next transaction is taken meanwhile and
//  waits in its last step until the result register drains.
module free_stack_block_allocator #(
    parameter int MAX_BLOCKS = 256,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [fsb_pkg::ACT_W-1:0]         i_action,
    input  logic [ADDR_WIDTH-1:0]             i_address,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ADDR_WIDTH-1:0]             o_block_address,
    output logic [fsb_pkg::STAT_W-1:0]        o_status,
    output logic                              o_inside_pool,
    // configuration port
    input  logic                              i_cfg_we,
    input  logic [fsb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [((ADDR_WIDTH > fsb_pkg::RECORDS_W) ? ADDR_WIDTH
                   : fsb_pkg::RECORDS_W)-1:0] i_cfg_data
);

    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int PROD_W = fsb_pkg::BB_W + CNT_W;
    localparam int EXT_W  = (ADDR_WIDTH > PROD_W) ? ADDR_WIDTH : PROD_W;
    localparam int DIV_W  = fsb_pkg::BB_W + IDX_W;
    localparam int RST_B  = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
    localparam int BIU_W  = (CNT_W > fsb_pkg::BLOCKS_W) ? CNT_W : fsb_pkg::BLOCKS_W;

    // configuration, kept in the form the datapath uses
    logic [ADDR_WIDTH-1:0]       r_base;
    logic [fsb_pkg::BB_W-1:0]    r_bb;        // 12 * block_records
    logic [CNT_W-1:0]            r_nblocks;   // min(blocks_in_use, MAX_BLOCKS)

    // stack control
    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            r_low;       // lowest fill since the last refill

    // transaction in flight
    fsb_pkg::t_state             r_state;
    fsb_pkg::t_state             n_state;
    fsb_pkg::t_action            r_action;
    logic [ADDR_WIDTH-1:0]       r_offset;
    logic [IDX_W-1:0]            r_pos;
    logic                        r_fill;      // popped entry lies below the low mark
    logic [PROD_W-1:0]           r_prod;
    logic [ADDR_WIDTH-1:0]       r_res_addr;
    fsb_pkg::t_status            r_res_status;
    logic                        r_res_inside;

    // result stage
    logic                        r_out_valid;
    logic [ADDR_WIDTH-1:0]       r_out_addr;
    fsb_pkg::t_status            r_out_status;
    logic                        r_out_inside;

    logic                        in_take;
    logic                        out_free;
    fsb_pkg::t_action            in_action;
    logic [CNT_W-1:0]            cnt_m1;
    logic [IDX_W-1:0]            alloc_idx;
    logic [EXT_W-1:0]            prod_ext;
    logic [EXT_W-1:0]            offset_ext;
    logic                        in_range;
    logic [BIU_W-1:0]            biu_ext;
    logic [BIU_W-1:0]            max_ext;

    logic                        mem_we;
    logic                        mem_re;
    logic [IDX_W-1:0]            mem_addr;
    logic [IDX_W-1:0]            mem_rdata;
    logic                        div_start;
    logic                        div_done;
    logic [IDX_W-1:0]            div_quot;

    assign in_action  = fsb_pkg::t_action'(i_action);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign cnt_m1     = r_count - CNT_W'(1);
    assign alloc_idx  = r_fill ? r_pos : mem_rdata;
    assign prod_ext   = EXT_W'(r_prod);
    assign offset_ext = EXT_W'(r_offset);
    assign in_range   = (offset_ext < prod_ext);
    assign biu_ext    = BIU_W'(i_cfg_data[fsb_pkg::BLOCKS_W-1:0]);
    assign max_ext    = BIU_W'(MAX_BLOCKS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_bb      <= fsb_pkg::BB_W'(fsb_pkg::REC_BYTES);
            r_nblocks <= CNT_W'(RST_B);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fsb_pkg::CFG_BASE: begin
                    r_base <= i_cfg_data[ADDR_WIDTH-1:0];
                end
                fsb_pkg::CFG_RECORDS: begin
                    r_bb <= fsb_pkg::BB_W'(i_cfg_data[fsb_pkg::RECORDS_W-1:0])
                            * fsb_pkg::BB_W'(fsb_pkg::REC_BYTES);
                end
                fsb_pkg::CFG_BLOCKS: begin
                    r_nblocks <= (biu_ext > max_ext) ? CNT_W'(MAX_BLOCKS)
                                                     : CNT_W'(biu_ext);
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            fsb_pkg::ST_IDLE: begin
                if (in_take) begin
                    case (in_action)
                        fsb_pkg::ACT_REINIT: n_state = fsb_pkg::ST_DONE;
                        fsb_pkg::ACT_ALLOC:  n_state = (r_count == '0) ? fsb_pkg::ST_DONE
                                                                       : fsb_pkg::ST_FETCH;
                        fsb_pkg::ACT_FREE:   n_state = (r_count >= r_nblocks) ? fsb_pkg::ST_DONE
                                                                              : fsb_pkg::ST_SIZE;
                        default:             n_state = fsb_pkg::ST_SIZE;
                    endcase
                end
            end
            fsb_pkg::ST_FETCH: n_state = fsb_pkg::ST_ADDR;
            fsb_pkg::ST_ADDR:  n_state = fsb_pkg::ST_DONE;
            fsb_pkg::ST_SIZE:  n_state = fsb_pkg::ST_RANGE;
            fsb_pkg::ST_RANGE: begin
                if (r_action == fsb_pkg::ACT_FREE && in_range) begin
                    n_state = fsb_pkg::ST_DIV;
                end else begin
                    n_state = fsb_pkg::ST_DONE;
                end
            end
            fsb_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = fsb_pkg::ST_PUSH;
                end
            end
            fsb_pkg::ST_PUSH: n_state = fsb_pkg::ST_DONE;
            fsb_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = fsb_pkg::ST_IDLE;
                end
            end
            default: n_state = fsb_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: memory port, divider start, input stall
    // ------------------------------------------------------------------
    always_comb begin
        o_in_stall = (r_state != fsb_pkg::ST_IDLE);
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = cnt_m1[IDX_W-1:0];
        div_start  = 1'b0;
        case (r_state)
            fsb_pkg::ST_IDLE: begin
                // pop: read the top entry while the transaction is taken
                mem_re = in_take && (in_action == fsb_pkg::ACT_ALLOC) && (r_count != '0);
            end
            fsb_pkg::ST_RANGE: begin
                div_start = (r_action == fsb_pkg::ACT_FREE) && in_range;
            end
            fsb_pkg::ST_PUSH: begin
                mem_we   = 1'b1;
                mem_addr = r_count[IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State, stack count and low mark
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsb_pkg::ST_IDLE;
            r_count <= CNT_W'(RST_B);
            r_low   <= CNT_W'(RST_B);
        end else begin
            r_state <= n_state;
            if (r_state == fsb_pkg::ST_IDLE && in_take) begin
                if (in_action == fsb_pkg::ACT_REINIT) begin
                    r_count <= r_nblocks;
                    r_low   <= r_nblocks;
                end else if (mem_re) begin
                    r_count <= cnt_m1;
                    if (cnt_m1 < r_low) begin
                        r_low <= cnt_m1;
                    end
                end
            end else if (r_state == fsb_pkg::ST_PUSH) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Transaction datapath
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            fsb_pkg::ST_IDLE: begin
                if (in_take) begin
                    r_action     <= in_action;
                    r_offset     <= i_address - r_base;
                    r_pos        <= cnt_m1[IDX_W-1:0];
                    r_fill       <= (cnt_m1 < r_low);
                    r_res_addr   <= '0;
                    r_res_inside <= 1'b0;
                    r_res_status <= fsb_pkg::STAT_OK;
                    if (in_action == fsb_pkg::ACT_ALLOC && r_count == '0) begin
                        r_res_status <= fsb_pkg::STAT_EMPTY;
                    end else if (in_action == fsb_pkg::ACT_FREE && r_count >= r_nblocks) begin
                        r_res_status <= fsb_pkg::STAT_FULL;
                    end
                end
            end
            fsb_pkg::ST_FETCH: begin
                r_prod <= PROD_W'(alloc_idx) * PROD_W'(r_bb);
            end
            fsb_pkg::ST_ADDR: begin
                r_res_addr <= r_base + prod_ext[ADDR_WIDTH-1:0];
            end
            fsb_pkg::ST_SIZE: begin
                r_prod <= PROD_W'(r_bb) * PROD_W'(r_nblocks);
            end
            fsb_pkg::ST_RANGE: begin
                if (r_action == fsb_pkg::ACT_QUERY) begin
                    r_res_inside <= in_range;
                end else if (!in_range) begin
                    r_res_status <= fsb_pkg::STAT_OUTSIDE;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result register: parts the sequencer from a stalled consumer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == fsb_pkg::ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == fsb_pkg::ST_DONE && out_free) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
            r_out_inside <= r_res_inside;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_block_address = r_out_addr;
    assign o_status        = r_out_status;
    assign o_inside_pool   = r_out_inside;

    // ------------------------------------------------------------------
    // Stack memory and divider
    // ------------------------------------------------------------------
    // Pops read in the accepting cycle of an alloc and pushes write in the push step of a free;
    // one transaction runs at a time, so the port never sees overlapping accesses.
    fsb_stack_mem #(
        .DEPTH  (MAX_BLOCKS),
        .ADDR_W (IDX_W),
        .DATA_W (IDX_W)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (div_quot),
        .o_rdata (mem_rdata)
    );

    // The range check has passed, so the quotient is below B and fits IDX_W bits.
    fsb_div #(
        .Q_W   (IDX_W),
        .DVS_W (fsb_pkg::BB_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (offset_ext[DIV_W-1:0]),
        .i_divisor  (r_bb),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCKS))
        else $error("free count above stack depth");

    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_count)
        else $error("low mark above free count");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_count < r_nblocks))
        else $error("push into a full stack");

    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fsb_pkg::ST_PUSH) |-> (CNT_W'(div_quot) < r_nblocks))
        else $error("freed block index outside the pool");

    a_div_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == fsb_pkg::ST_DIV))
        else $error("divider finished outside the divide step");

endmodule
